@@ design/assert_macros.svh @@
// Assertion macros used by the keyframe weight sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/kws_pkg.sv @@
// Types and constants for the keyframe weight sampler.
package kws_pkg;

    localparam int KWS_MAX_KEYS = 16;

    localparam int TIME_W   = 32;
    localparam int WEIGHT_W = 16;
    localparam int CFG_DW   = 32;
    localparam int PADDR_W  = 4;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int FRAC_W   = 17;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_PLAYING   = 2'd0;
    localparam logic [1:0] REG_LOOP      = 2'd1;
    localparam logic [1:0] REG_KEY_COUNT = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]          key_t;
        logic signed [WEIGHT_W-1:0] w1;
        logic signed [WEIGHT_W-1:0] w2;
    } t_entry;

endpackage

@@ design/keyframe_weight_sampler.sv @@
// Keyframe weight sampler: key table, key search, serial divide and shared blend multiplier.
// Write and restart beats, ticks while stopped and cmd 3 each take one cycle.
// A playing tick checks the last key, then searches the keys in order and fetches the key pair,
// and runs the serial divider only when the playhead lies strictly inside a rising key span.
// It waits in S_DONE while the output is stalled, then returns to idle for the next beat.
// Synchronous active-low reset clears control, config and playhead; the key table is not cleared.
module keyframe_weight_sampler #(
    parameter int MAX_KEYS = kws_pkg::KWS_MAX_KEYS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_cmd,
    input  logic [kws_pkg::TIME_W-1:0]            i_frame_time,
    input  logic [kws_pkg::SLOT_W-1:0]            i_key_slot,
    input  logic [kws_pkg::TIME_W-1:0]            i_key_time,
    input  logic signed [kws_pkg::WEIGHT_W-1:0]   i_key_first_weight,
    input  logic signed [kws_pkg::WEIGHT_W-1:0]   i_key_second_weight,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [kws_pkg::WEIGHT_W-1:0]   o_first_weight,
    output logic signed [kws_pkg::WEIGHT_W-1:0]   o_second_weight,
    output logic [kws_pkg::TIME_W-1:0]            o_playhead,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [kws_pkg::PADDR_W-1:0]           paddr,
    input  logic [kws_pkg::CFG_DW-1:0]            pwdata,
    output logic [kws_pkg::CFG_DW-1:0]            prdata,
    output logic                                  pready
);
    import kws_pkg::*;

    `include "assert_macros.svh"

    localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_LRD  = 14'b00000000000010,
        S_LCHK = 14'b00000000000100,
        S_SRD  = 14'b00000000001000,
        S_SCHK = 14'b00000000010000,
        S_K0RD = 14'b00000000100000,
        S_K0   = 14'b00000001000000,
        S_K1RD = 14'b00000010000000,
        S_K1   = 14'b00000100000000,
        S_DCHK = 14'b00001000000000,
        S_DIV  = 14'b00010000000000,
        S_MUL1 = 14'b00100000000000,
        S_MUL2 = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic               r_playing;
    logic               r_loop;
    logic [COUNT_W-1:0] r_key_count;

    // key table
    t_entry             r_mem [MAX_KEYS];
    t_entry             r_rd;
    logic [KW-1:0]      r_addr;

    // tick datapath
    logic [TIME_W-1:0]          r_p;
    logic [NW-1:0]              r_n;
    logic [KW-1:0]              r_idx;
    logic [KW-1:0]              r_k0;
    logic [KW-1:0]              r_k1;
    logic [TIME_W-1:0]          r_t0;
    logic [TIME_W-1:0]          r_t1;
    logic signed [WEIGHT_W-1:0] r_a1, r_a2, r_b1, r_b2;
    logic [TIME_W-1:0]          r_rem;
    logic [TIME_W-1:0]          r_d;
    logic [15:0]                r_q;
    logic [3:0]                 r_cnt;
    logic [FRAC_W-1:0]          r_frac;
    logic signed [34:0]         r_prod;
    logic signed [WEIGHT_W-1:0] r_w1;

    // output register
    logic                       r_out_valid;
    logic signed [WEIGHT_W-1:0] r_out_w1;
    logic signed [WEIGHT_W-1:0] r_out_w2;
    logic [TIME_W-1:0]          r_out_p;

    logic                w_in_acc;
    logic                w_cfg_wr;
    logic [NW-1:0]       w_n;
    logic [TIME_W:0]     w_sum;
    logic [TIME_W-1:0]   w_p_sat;
    logic [KW-1:0]       w_last;
    logic [TIME_W-1:0]   w_span;
    logic [TIME_W-1:0]   w_off;
    logic [TIME_W:0]     w_shift;
    logic [TIME_W+1:0]   w_dsub;
    logic signed [16:0]  w_diff1;
    logic signed [16:0]  w_diff2;
    logic signed [16:0]  w_mul_d;
    logic signed [34:0]  w_prod;
    logic signed [34:0]  w_rsum;
    logic signed [WEIGHT_W-1:0] w_base;
    logic signed [WEIGHT_W-1:0] w_blend;
    logic                w_out_free;

    assign w_in_acc   = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign w_cfg_wr   = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_n = (32'(r_key_count) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(r_key_count);
    assign w_sum   = {1'b0, r_p} + {1'b0, i_frame_time};
    assign w_p_sat = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];
    assign w_last  = KW'(r_n - NW'(1));

    assign w_span = r_t1 - r_t0;
    assign w_off  = r_p - r_t0;

    // one restoring divide step
    assign w_shift = {r_rem, 1'b0};
    assign w_dsub  = {1'b0, w_shift} - {2'b00, r_d};

    // shared blend multiplier
    assign w_diff1 = {r_b1[WEIGHT_W-1], r_b1} - {r_a1[WEIGHT_W-1], r_a1};
    assign w_diff2 = {r_b2[WEIGHT_W-1], r_b2} - {r_a2[WEIGHT_W-1], r_a2};
    assign w_mul_d = (r_state == S_MUL2) ? w_diff2 : w_diff1;
    assign w_prod  = 35'(w_mul_d * $signed({1'b0, r_frac}));

    // round half up, then add to the base weight
    assign w_rsum  = r_prod + 35'sd32768;
    assign w_base  = (r_state == S_DONE) ? r_a2 : r_a1;
    assign w_blend = w_base + $signed(w_rsum[31:16]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing   <= 1'b0;
            r_loop      <= 1'b0;
            r_key_count <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_PLAYING:   r_playing   <= pwdata[0];
                REG_LOOP:      r_loop      <= pwdata[0];
                REG_KEY_COUNT: r_key_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PLAYING:   prdata = {{(CFG_DW-1){1'b0}}, r_playing};
            REG_LOOP:      prdata = {{(CFG_DW-1){1'b0}}, r_loop};
            REG_KEY_COUNT: prdata = {{(CFG_DW-COUNT_W){1'b0}}, r_key_count};
            default:       prdata = '0;
        endcase
    end

    // key table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == CMD_WRITE) && (32'(i_key_slot) < 32'(MAX_KEYS))) begin
            r_mem[KW'(i_key_slot)] <= '{key_t: i_key_time,
                                        w1: i_key_first_weight,
                                        w2: i_key_second_weight};
        end
        r_rd <= r_mem[r_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_cmd == CMD_TICK) && r_playing && (w_n != '0)) begin
                    n_state = S_LRD;
                end
            end
            S_LRD:  n_state = S_LCHK;
            S_LCHK: begin
                if ((r_p >= r_rd.key_t) || (r_n == NW'(1))) begin
                    n_state = S_K0RD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD:  n_state = S_SCHK;
            S_SCHK: begin
                if ((r_p < r_rd.key_t) || (r_idx == w_last)) begin
                    n_state = S_K0RD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_K0RD: n_state = S_K0;
            S_K0:   n_state = S_K1RD;
            S_K1RD: n_state = S_K1;
            S_K1:   n_state = S_DCHK;
            S_DCHK: begin
                if ((r_t1 > r_t0) && (r_p > r_t0) && (w_off < w_span)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // playhead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
        end else if (w_in_acc && (i_cmd == CMD_RESTART)) begin
            r_p <= '0;
        end else if ((r_state == S_IDLE) && (n_state == S_LRD)) begin
            r_p <= w_p_sat;
        end else if ((r_state == S_LCHK) && (r_p >= r_rd.key_t)) begin
            r_p <= r_loop ? '0 : r_rd.key_t;
        end
    end

    // tick datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n    <= w_n;
                r_addr <= KW'(w_n - NW'(1));
            end
            S_LCHK: begin
                if (r_p >= r_rd.key_t) begin
                    // wrap to the start or clamp on the last key
                    if (r_loop) begin
                        r_k0   <= '0;
                        r_k1   <= (r_n > NW'(1)) ? KW'(1) : '0;
                        r_addr <= '0;
                    end else begin
                        r_k0   <= w_last;
                        r_k1   <= w_last;
                        r_addr <= w_last;
                    end
                end else if (r_n == NW'(1)) begin
                    r_k0   <= '0;
                    r_k1   <= '0;
                    r_addr <= '0;
                end else begin
                    r_idx  <= KW'(1);
                    r_addr <= KW'(1);
                end
            end
            S_SCHK: begin
                if (r_p < r_rd.key_t) begin
                    r_k0   <= r_idx - KW'(1);
                    r_k1   <= r_idx;
                    r_addr <= r_idx - KW'(1);
                end else if (r_idx == w_last) begin
                    r_k0   <= '0;
                    r_k1   <= w_last;
                    r_addr <= '0;
                end else begin
                    r_idx  <= r_idx + KW'(1);
                    r_addr <= r_idx + KW'(1);
                end
            end
            S_K0: begin
                r_t0   <= r_rd.key_t;
                r_a1   <= r_rd.w1;
                r_a2   <= r_rd.w2;
                r_addr <= r_k1;
            end
            S_K1: begin
                r_t1 <= r_rd.key_t;
                r_b1 <= r_rd.w1;
                r_b2 <= r_rd.w2;
            end
            S_DCHK: begin
                r_rem <= w_off;
                r_d   <= w_span;
                r_q   <= '0;
                r_cnt <= '0;
                if ((r_t1 > r_t0) && (r_p > r_t0)) begin
                    // saturate the fraction at one
                    r_frac <= (w_off >= w_span) ? FRAC_W'(17'h10000) : '0;
                end else begin
                    r_frac <= '0;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt + 4'd1;
                if (!w_dsub[TIME_W+1]) begin
                    r_rem <= w_dsub[TIME_W-1:0];
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_rem <= w_shift[TIME_W-1:0];
                    r_q   <= {r_q[14:0], 1'b0};
                end
                if (r_cnt == 4'd15) begin
                    r_frac <= {1'b0, r_q[14:0], !w_dsub[TIME_W+1]};
                end
            end
            S_MUL1: begin
                r_prod <= w_prod;
            end
            S_MUL2: begin
                r_w1   <= w_blend;
                r_prod <= w_prod;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_w1 <= r_w1;
            r_out_w2 <= w_blend;
            r_out_p  <= r_p;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_first_weight  = r_out_w1;
    assign o_second_weight = r_out_w2;
    assign o_playhead      = r_out_p;

    `ASSERT_CLK(a_div_rem_below_span, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem < r_d), "divider remainder not below span")
    `ASSERT_CLK(a_frac_in_range, i_clk, i_rst_n, (r_state == S_MUL1) |-> (r_frac <= FRAC_W'(17'h10000)), "fraction above one")
    `ASSERT_CLK(a_restart_zeroes, i_clk, i_rst_n, (w_in_acc && (i_cmd == CMD_RESTART)) |=> (r_p == '0), "restart left playhead nonzero")
    `ASSERT_CLK(a_non_tick_one_cycle, i_clk, i_rst_n, (w_in_acc && (i_cmd != CMD_TICK)) |=> (r_state == S_IDLE), "non-tick beat left sequencer busy")
    `ASSERT_CLK(a_weight_bracketed, i_clk, i_rst_n, $rose(r_out_valid) |-> ((r_out_w1 >= r_a1 && r_out_w1 <= r_b1) || (r_out_w1 >= r_b1 && r_out_w1 <= r_a1)), "first weight outside key pair")

endmodule
